// ===== hdl/frt_pkg.sv =====
// Shared types and constants for the fragment reassembly tracker.
package frt_pkg;

  localparam int MAX_PIECES = 96;
  localparam int MAP_IDX_W  = $clog2(MAX_PIECES);
  localparam int COUNT_W    = $clog2(MAX_PIECES + 1);
  localparam int CHUNK_W    = 10;
  localparam int LIMIT_W    = 16;
  localparam int PLEN_W     = 10;
  localparam int PROD_W     = 8 + CHUNK_W;
  localparam int END_W      = PROD_W + 1;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_SIZE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MESSAGE_LIMIT = 1'd1;

  localparam logic [CHUNK_W-1:0] CHUNK_SIZE_RESET    = 10'd200;
  localparam logic [LIMIT_W-1:0] MESSAGE_LIMIT_RESET = 16'd16384;

  typedef enum logic [2:0] {
    V_WHOLE     = 3'd0,
    V_STORED    = 3'd1,
    V_DONE      = 3'd2,
    V_TOO_MANY  = 3'd3,
    V_NO_FIT    = 3'd4,
    V_MISMATCH  = 3'd5,
    V_DUPLICATE = 3'd6,
    V_OVERFLOW  = 3'd7
  } verdict_t;

  typedef struct packed {
    logic              frag;
    logic [15:0]       seq;
    logic [7:0]        idx;
    logic [7:0]        cnt;
    logic [7:0]        kind;
    logic [31:0]       req;
    logic [31:0]       sess;
    logic [PLEN_W-1:0] plen;
  } frame_t;

  // Frame header with its two products against the chunk size.
  typedef struct packed {
    frame_t            hdr;
    logic [PROD_W-1:0] offset;
    logic [PROD_W-1:0] need;
  } staged_t;

  typedef struct packed {
    verdict_t           verdict;
    logic [15:0]        write_offset;
    logic [7:0]         kind;
    logic [31:0]        req;
    logic [31:0]        sess;
    logic [15:0]        length;
    logic [COUNT_W-1:0] abandoned;
  } result_t;

  typedef struct packed {
    logic                  busy;
    logic [15:0]           seq;
    logic [7:0]            kind;
    logic [31:0]           req;
    logic [31:0]           sess;
    logic [COUNT_W-1:0]    expected;
    logic [COUNT_W-1:0]    received;
    logic [15:0]           assembled;
    logic [MAX_PIECES-1:0] seen;
  } track_t;

endpackage

// ===== hdl/frt_tracker.sv =====
// Message state and the per-frame decision of the reassembly tracker.
module frt_tracker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  frt_pkg::staged_t            item,
  input  logic [frt_pkg::LIMIT_W-1:0] message_limit,
  output frt_pkg::result_t            result
);

  frt_pkg::track_t st;
  frt_pkg::track_t st_next;

  always_comb begin
    logic                        abandon;
    logic                        open_fail;
    logic [frt_pkg::END_W-1:0]   off_end;
    logic [frt_pkg::COUNT_W-1:0] recv_inc;

    abandon   = st.busy && (!item.hdr.frag || item.hdr.seq != st.seq);
    open_fail = 1'b0;
    off_end   = frt_pkg::END_W'(item.offset) + frt_pkg::END_W'(item.hdr.plen);
    recv_inc  = '0;
    st_next   = st;

    result              = '0;
    result.verdict      = frt_pkg::V_MISMATCH;
    result.abandoned    = abandon ? st.received : '0;

    // Dropping a partial message clears the map and counts but keeps its identity.
    if (abandon) begin
      st_next.busy      = 1'b0;
      st_next.expected  = '0;
      st_next.received  = '0;
      st_next.assembled = '0;
      st_next.seen      = '0;
    end

    if (!item.hdr.frag) begin
      result.verdict = frt_pkg::V_WHOLE;
      result.kind    = item.hdr.kind;
      result.req     = item.hdr.req;
      result.sess    = item.hdr.sess;
      result.length  = 16'(item.hdr.plen);
    end else begin
      if (!st_next.busy) begin
        if (item.hdr.cnt > 8'(frt_pkg::MAX_PIECES)) begin
          result.verdict = frt_pkg::V_TOO_MANY;
          open_fail      = 1'b1;
        end else if (item.need > frt_pkg::PROD_W'(message_limit)) begin
          result.verdict = frt_pkg::V_NO_FIT;
          open_fail      = 1'b1;
        end else begin
          st_next.busy      = 1'b1;
          st_next.seq       = item.hdr.seq;
          st_next.kind      = item.hdr.kind;
          st_next.req       = item.hdr.req;
          st_next.sess      = item.hdr.sess;
          st_next.expected  = item.hdr.cnt[frt_pkg::COUNT_W-1:0];
          st_next.received  = '0;
          st_next.assembled = '0;
          st_next.seen      = '0;
        end
      end

      if (!open_fail) begin
        recv_inc = st_next.received + frt_pkg::COUNT_W'(1);
        if (item.hdr.cnt != 8'(st_next.expected) || item.hdr.idx >= 8'(st_next.expected)
            || item.hdr.kind != st_next.kind || item.hdr.req != st_next.req
            || item.hdr.sess != st_next.sess) begin
          result.verdict = frt_pkg::V_MISMATCH;
        end else if (item.hdr.idx >= 8'(frt_pkg::MAX_PIECES)
                     || st_next.seen[item.hdr.idx[frt_pkg::MAP_IDX_W-1:0]]) begin
          result.verdict = frt_pkg::V_DUPLICATE;
        end else if (off_end > frt_pkg::END_W'(message_limit)) begin
          result.verdict = frt_pkg::V_OVERFLOW;
        end else begin
          result.write_offset = item.offset[15:0];
          st_next.seen[item.hdr.idx[frt_pkg::MAP_IDX_W-1:0]] = 1'b1;
          st_next.received = recv_inc;
          if (off_end > frt_pkg::END_W'(st_next.assembled)) begin
            st_next.assembled = off_end[15:0];
          end
          if (recv_inc == st_next.expected) begin
            result.verdict    = frt_pkg::V_DONE;
            result.kind       = st_next.kind;
            result.req        = st_next.req;
            result.sess       = st_next.sess;
            result.length     = st_next.assembled;
            st_next.busy      = 1'b0;
            st_next.expected  = '0;
            st_next.received  = '0;
            st_next.assembled = '0;
            st_next.seen      = '0;
          end else begin
            result.verdict = frt_pkg::V_STORED;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (load) begin
      st <= st_next;
    end
  end

endmodule

// ===== hdl/fragment_reassembly_tracker_top.sv =====
// Top level of the fragment reassembly tracker: pipeline, configuration and result register.
//
//   channel | handshake          | payload
//   --------+--------------------+------------------------------------------------
//   input   | in_valid, in_stall | is_fragmented .. piece_length (frame header)
//   output  | out_valid, out_stall | verdict .. abandoned_pieces (one per header)
//   config  | cfg_write          | cfg_index, cfg_data (chunk size, message limit)
//
// One header is taken per cycle while the input is not stalled; each result passes the
// input register, the product stage and then the tracker decision that loads the result
// register before it is on the outputs. Reset clears the message state and restores the
// register defaults. A stalled output holds its result while the stages behind it keep
// filling, and the input stalls only once every stage is occupied.
module fragment_reassembly_tracker_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [frt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [frt_pkg::LIMIT_W-1:0]  cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         is_fragmented,
  input  logic [15:0]                  message_seq,
  input  logic [7:0]                   piece_index,
  input  logic [7:0]                   piece_count,
  input  logic [7:0]                   message_kind,
  input  logic [31:0]                  request_tag,
  input  logic [31:0]                  session_tag,
  input  logic [frt_pkg::PLEN_W-1:0]   piece_length,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [2:0]                   verdict,
  output logic [15:0]                  write_offset,
  output logic [7:0]                   deliver_kind,
  output logic [31:0]                  deliver_request,
  output logic [31:0]                  deliver_session,
  output logic [15:0]                  deliver_length,
  output logic [frt_pkg::COUNT_W-1:0]  abandoned_pieces
);

  logic [frt_pkg::CHUNK_W-1:0] chunk_size;
  logic [frt_pkg::LIMIT_W-1:0] message_limit;

  logic              s1_valid;
  frt_pkg::frame_t   s1;
  logic              s2_valid;
  frt_pkg::staged_t  s2;
  frt_pkg::result_t  result;
  frt_pkg::result_t  out_reg;

  logic in_take;
  logic s2_load;
  logic out_load;

  assign out_load = s2_valid && (!out_valid || !out_stall);
  assign s2_load  = s1_valid && (!s2_valid || out_load);
  assign in_stall = s1_valid && !s2_load;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_size    <= frt_pkg::CHUNK_SIZE_RESET;
      message_limit <= frt_pkg::MESSAGE_LIMIT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        frt_pkg::REG_CHUNK_SIZE:    chunk_size    <= cfg_data[frt_pkg::CHUNK_W-1:0];
        frt_pkg::REG_MESSAGE_LIMIT: message_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid <= 1'b1;
      end else if (s2_load) begin
        s1_valid <= 1'b0;
      end
      if (s2_load) begin
        s2_valid <= 1'b1;
      end else if (out_load) begin
        s2_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1.frag <= is_fragmented;
      s1.seq  <= message_seq;
      s1.idx  <= piece_index;
      s1.cnt  <= piece_count;
      s1.kind <= message_kind;
      s1.req  <= request_tag;
      s1.sess <= session_tag;
      s1.plen <= piece_length;
    end
  end

  // Both products depend only on the header and the chunk size, so they are formed
  // ahead of the stage that reads the message state.
  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2.hdr    <= s1;
      s2.offset <= frt_pkg::PROD_W'(s1.idx) * frt_pkg::PROD_W'(chunk_size);
      s2.need   <= frt_pkg::PROD_W'(s1.cnt) * frt_pkg::PROD_W'(chunk_size);
    end
  end

  frt_tracker u_tracker (
    .clk           (clk),
    .rst           (rst),
    .load          (out_load),
    .item          (s2),
    .message_limit (message_limit),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_reg <= result;
    end
  end

  assign verdict          = out_reg.verdict;
  assign write_offset     = out_reg.write_offset;
  assign deliver_kind     = out_reg.kind;
  assign deliver_request  = out_reg.req;
  assign deliver_session  = out_reg.sess;
  assign deliver_length   = out_reg.length;
  assign abandoned_pieces = out_reg.abandoned;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the fragment reassembly tracker, with its own tracker predictor.
module tb_top;

  localparam int RESET_CYCLES = 9;
  localparam int LONG_HOLD    = 200;
  localparam int STUCK_LIMIT  = 2000;
  localparam int TOTAL_FRAMES = 2050;
  localparam int QUIET_FRAMES = 300;
  localparam int TAIL_CYCLES  = 16;
  localparam int CFG_SPAN     = 250;

  logic                          clk;
  logic                          rst;
  logic                          cfg_write;
  logic [frt_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [frt_pkg::LIMIT_W-1:0]   cfg_data;
  logic                          in_valid;
  logic                          in_stall;
  logic                          is_fragmented;
  logic [15:0]                   message_seq;
  logic [7:0]                    piece_index;
  logic [7:0]                    piece_count;
  logic [7:0]                    message_kind;
  logic [31:0]                   request_tag;
  logic [31:0]                   session_tag;
  logic [frt_pkg::PLEN_W-1:0]    piece_length;
  logic                          out_valid;
  logic                          out_stall;
  logic [2:0]                    verdict;
  logic [15:0]                   write_offset;
  logic [7:0]                    deliver_kind;
  logic [31:0]                   deliver_request;
  logic [31:0]                   deliver_session;
  logic [15:0]                   deliver_length;
  logic [frt_pkg::COUNT_W-1:0]   abandoned_pieces;

  fragment_reassembly_tracker_top i_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .is_fragmented    (is_fragmented),
    .message_seq      (message_seq),
    .piece_index      (piece_index),
    .piece_count      (piece_count),
    .message_kind     (message_kind),
    .request_tag      (request_tag),
    .session_tag      (session_tag),
    .piece_length     (piece_length),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .verdict          (verdict),
    .write_offset     (write_offset),
    .deliver_kind     (deliver_kind),
    .deliver_request  (deliver_request),
    .deliver_session  (deliver_session),
    .deliver_length   (deliver_length),
    .abandoned_pieces (abandoned_pieces)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Tracker state as the predictor sees it.
  logic                           busy;
  logic [15:0]                    cur_seq;
  logic [7:0]                     cur_kind;
  logic [31:0]                    cur_req;
  logic [31:0]                    cur_sess;
  logic [frt_pkg::COUNT_W-1:0]    want_cnt;
  logic [frt_pkg::COUNT_W-1:0]    got_cnt;
  logic [15:0]                    span;
  logic [frt_pkg::MAX_PIECES-1:0] seen_pieces;
  logic [frt_pkg::CHUNK_W-1:0]    chunk_bytes;
  logic [frt_pkg::LIMIT_W-1:0]    limit_bytes;

  frt_pkg::result_t awaited_verdicts[$];

  int  frames_sent;
  int  results_seen;
  int  faults;
  int  stuck_cycles;
  bit  quiet;
  int  hold_asks;

  function automatic void clear_track();
    busy        = 1'b0;
    want_cnt    = '0;
    got_cnt     = '0;
    span        = '0;
    seen_pieces = '0;
  endfunction

  // Works out the verdict for one header and moves the tracker state on.
  function automatic frt_pkg::result_t track_frame(frt_pkg::frame_t f);
    frt_pkg::result_t r;
    int               off;
    int               need;
    r = '0;
    r.verdict = frt_pkg::V_WHOLE;
    if (!f.frag) begin
      if (busy) begin
        r.abandoned = got_cnt;
        clear_track();
      end
      r.kind   = f.kind;
      r.req    = f.req;
      r.sess   = f.sess;
      r.length = 16'(f.plen);
      return r;
    end
    if (busy && f.seq != cur_seq) begin
      r.abandoned = got_cnt;
      clear_track();
    end
    if (!busy) begin
      need = int'(f.cnt) * int'(chunk_bytes);
      if (int'(f.cnt) > frt_pkg::MAX_PIECES) begin
        r.verdict = frt_pkg::V_TOO_MANY;
        return r;
      end
      if (need > int'(limit_bytes)) begin
        r.verdict = frt_pkg::V_NO_FIT;
        return r;
      end
      clear_track();
      busy     = 1'b1;
      cur_seq  = f.seq;
      cur_kind = f.kind;
      cur_req  = f.req;
      cur_sess = f.sess;
      want_cnt = frt_pkg::COUNT_W'(f.cnt);
    end
    if (int'(f.cnt) != int'(want_cnt) || int'(f.idx) >= int'(want_cnt) ||
        f.kind != cur_kind || f.req != cur_req || f.sess != cur_sess) begin
      r.verdict = frt_pkg::V_MISMATCH;
      return r;
    end
    if (int'(f.idx) >= frt_pkg::MAX_PIECES ||
        seen_pieces[f.idx[frt_pkg::MAP_IDX_W-1:0]]) begin
      r.verdict = frt_pkg::V_DUPLICATE;
      return r;
    end
    off = int'(f.idx) * int'(chunk_bytes);
    if (off + int'(f.plen) > int'(limit_bytes)) begin
      r.verdict = frt_pkg::V_OVERFLOW;
      return r;
    end
    seen_pieces[f.idx[frt_pkg::MAP_IDX_W-1:0]] = 1'b1;
    got_cnt = got_cnt + frt_pkg::COUNT_W'(1);
    if (off + int'(f.plen) > int'(span))
      span = 16'(off + int'(f.plen));
    r.write_offset = 16'(off);
    if (got_cnt == want_cnt) begin
      r.verdict = frt_pkg::V_DONE;
      r.kind    = cur_kind;
      r.req     = cur_req;
      r.sess    = cur_sess;
      r.length  = span;
      clear_track();
    end else begin
      r.verdict = frt_pkg::V_STORED;
    end
    return r;
  endfunction

  function automatic frt_pkg::frame_t mk(logic frag, logic [15:0] seq, logic [7:0] idx,
                                         logic [7:0] cnt, logic [7:0] kind,
                                         logic [31:0] req, logic [31:0] sess,
                                         logic [frt_pkg::PLEN_W-1:0] plen);
    frt_pkg::frame_t f;
    f.frag = frag;
    f.seq  = seq;
    f.idx  = idx;
    f.cnt  = cnt;
    f.kind = kind;
    f.req  = req;
    f.sess = sess;
    f.plen = plen;
    return f;
  endfunction

  function automatic frt_pkg::frame_t random_frame();
    frt_pkg::frame_t f;
    f.frag = 1'($urandom);
    f.seq  = 16'($urandom);
    f.idx  = ($urandom_range(0, 1) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8));
    f.cnt  = ($urandom_range(0, 1) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8));
    f.kind = 8'($urandom);
    f.req  = $urandom;
    f.sess = $urandom;
    f.plen = frt_pkg::PLEN_W'($urandom);
    return f;
  endfunction

  // Offers one header, holds it until the transfer, then records its verdict.
  task automatic send_frame(frt_pkg::frame_t f);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid      = 1'b1;
    is_fragmented = f.frag;
    message_seq   = f.seq;
    piece_index   = f.idx;
    piece_count   = f.cnt;
    message_kind  = f.kind;
    request_tag   = f.req;
    session_tag   = f.sess;
    piece_length  = f.plen;
    do @(posedge clk); while (in_stall);
    awaited_verdicts.push_back(track_frame(f));
    frames_sent++;
  endtask

  task automatic drain_verdicts();
    @(negedge clk);
    in_valid = 1'b0;
    while (awaited_verdicts.size() != 0) @(posedge clk);
  endtask

  // Every header yields a verdict, so an empty queue means nothing is in flight.
  task automatic write_reg(logic [frt_pkg::CFG_IDX_W-1:0] idx,
                           logic [frt_pkg::LIMIT_W-1:0] data);
    drain_verdicts();
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    if (idx == frt_pkg::REG_CHUNK_SIZE)
      chunk_bytes = data[frt_pkg::CHUNK_W-1:0];
    else
      limit_bytes = data;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // A broken header derived from the message being sent.
  task automatic send_noise(frt_pkg::frame_t f, int stored_idx);
    frt_pkg::frame_t n;
    n = f;
    case ($urandom_range(0, 7))
      0: n.idx = (stored_idx >= 0) ? 8'(stored_idx) : 8'($urandom);
      1: n.kind = f.kind + 8'($urandom_range(1, 255));
      2: n.req = f.req ^ (32'd1 << $urandom_range(0, 31));
      3: n.sess = f.sess ^ (32'd1 << $urandom_range(0, 31));
      4: n.cnt = f.cnt + 8'($urandom_range(1, 255));
      5: n.idx = 8'($urandom_range(int'(f.cnt), 255));
      6: begin
        n = random_frame();
        n.frag = 1'b0;
      end
      default: n = random_frame();
    endcase
    send_frame(n);
  endtask

  // A whole message in random piece order, with the odd broken header mixed in.
  task automatic send_message();
    frt_pkg::frame_t f;
    int              maxfit;
    int              cnt;
    int              i;
    int              pick;
    int              tmp;
    int              order[frt_pkg::MAX_PIECES];
    maxfit = (chunk_bytes == 0) ? frt_pkg::MAX_PIECES
                                : int'(limit_bytes) / int'(chunk_bytes);
    if (maxfit > frt_pkg::MAX_PIECES)
      maxfit = frt_pkg::MAX_PIECES;
    if (maxfit == 0)
      cnt = $urandom_range(1, 8);
    else if ($urandom_range(0, 9) == 0)
      cnt = maxfit;
    else
      cnt = $urandom_range(1, (maxfit < 8) ? maxfit : 8);
    f.frag = 1'b1;
    f.seq  = 16'($urandom);
    f.idx  = '0;
    f.cnt  = 8'(cnt);
    f.kind = 8'($urandom);
    f.req  = $urandom;
    f.sess = $urandom;
    f.plen = '0;
    for (i = 0; i < cnt; i++)
      order[i] = i;
    for (i = cnt - 1; i > 0; i--) begin
      pick = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[pick];
      order[pick] = tmp;
    end
    for (i = 0; i < cnt; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_noise(f, (i > 0) ? order[0] : -1);
      f.idx = 8'(order[i]);
      if ($urandom_range(0, 19) == 0)
        f.plen = frt_pkg::PLEN_W'($urandom);
      else
        f.plen = frt_pkg::PLEN_W'($urandom_range(0, int'(chunk_bytes)));
      send_frame(f);
    end
  endtask

  task automatic test_whole_frames();
    send_frame(mk(1'b0, '0, '0, '0, '0, '0, '0, '0));
    send_frame(mk(1'b0, '1, '1, '1, '1, '1, '1, '1));
  endtask

  task automatic test_reassembly_cases();
    logic [7:0]  k;
    logic [31:0] r;
    logic [31:0] s;
    k = 8'h5A;
    r = 32'h0F1E_2D3C;
    s = 32'hC3D2_E1F0;
    send_frame(mk(1'b1, 16'd5, 8'd1, 8'd3, k, r, s, 10'd200));
    send_frame(mk(1'b1, 16'd5, 8'd1, 8'd3, k, r, s, 10'd200));
    send_frame(mk(1'b1, 16'd5, 8'd0, 8'd3, 8'(k + 1), r, s, 10'd0));
    send_frame(mk(1'b1, 16'd5, 8'd0, 8'd3, k, r ^ 32'd1, s, 10'd0));
    send_frame(mk(1'b1, 16'd5, 8'd0, 8'd3, k, r, s ^ 32'd1, 10'd0));
    send_frame(mk(1'b1, 16'd5, 8'd0, 8'd4, k, r, s, 10'd0));
    send_frame(mk(1'b1, 16'd5, 8'd3, 8'd3, k, r, s, 10'd0));
    send_frame(mk(1'b1, 16'd5, 8'd0, 8'd3, k, r, s, 10'd17));
    send_frame(mk(1'b1, 16'd5, 8'd2, 8'd3, k, r, s, 10'd1023));
    send_frame(mk(1'b1, 16'd6, 8'd0, 8'd97, k, r, s, 10'd1));
    send_frame(mk(1'b1, 16'd6, 8'd0, 8'd255, k, r, s, 10'd1));
    send_frame(mk(1'b1, 16'd6, 8'd0, 8'd96, k, r, s, 10'd1));
    send_frame(mk(1'b1, 16'd7, 8'd0, 8'd2, k, r, s, 10'd50));
    // A new sequence number abandons the open message and opens one with no pieces.
    send_frame(mk(1'b1, 16'd8, 8'd0, 8'd0, k, r, s, 10'd5));
    send_frame(mk(1'b1, 16'd8, 8'd0, 8'd0, k, r, s, 10'd5));
    send_frame(mk(1'b0, 16'd8, 8'd0, 8'd0, k, r, s, 10'd9));
    send_frame(mk(1'b1, 16'd9, 8'd80, 8'd81, k, r, s, 10'd0));
    send_frame(mk(1'b0, 16'd9, 8'd0, 8'd0, k, r, s, 10'd3));
  endtask

  task automatic test_tight_registers();
    logic [7:0]  k;
    logic [31:0] r;
    logic [31:0] s;
    k = 8'hA5;
    r = 32'h8000_0001;
    s = 32'h7FFF_FFFE;
    write_reg(frt_pkg::REG_CHUNK_SIZE, 16'd300);
    write_reg(frt_pkg::REG_MESSAGE_LIMIT, 16'd1000);
    send_frame(mk(1'b1, 16'd10, 8'd2, 8'd3, k, r, s, 10'd500));
    send_frame(mk(1'b1, 16'd10, 8'd2, 8'd3, k, r, s, 10'd400));
    send_frame(mk(1'b1, 16'd11, 8'd0, 8'd200, k, r, s, 10'd0));
    // With a zero chunk size every offset is zero and any count up to 96 fits the limit.
    write_reg(frt_pkg::REG_CHUNK_SIZE, 16'd0);
    send_frame(mk(1'b1, 16'd12, 8'd5, 8'd96, k, r, s, 10'd7));
  endtask

  task automatic run_setting(int chunk, int limit, int frames);
    int stop_at;
    write_reg(frt_pkg::REG_CHUNK_SIZE, 16'(chunk));
    write_reg(frt_pkg::REG_MESSAGE_LIMIT, 16'(limit));
    stop_at = frames_sent + frames;
    while (frames_sent < stop_at)
      send_message();
  endtask

  task automatic test_register_extremes();
    run_setting(1, 65535, 120);
    run_setting(1023, 65535, 120);
    run_setting(1023, 1, 120);
    run_setting(0, 0, 120);
    run_setting(512, 4096, 120);
    run_setting(1, 1, 120);
    run_setting(0, 65535, 120);
  endtask

  // The receiver holds off while headers keep coming, so the input side stalls.
  task automatic test_backpressure();
    int stop_at;
    write_reg(frt_pkg::REG_CHUNK_SIZE, 16'd16);
    write_reg(frt_pkg::REG_MESSAGE_LIMIT, 16'd1024);
    hold_asks++;
    stop_at = frames_sent + 40;
    while (frames_sent < stop_at)
      send_message();
    drain_verdicts();
  endtask

  task automatic test_random_traffic();
    int next_cfg;
    int chunk;
    int limit;
    next_cfg = frames_sent;
    while (frames_sent < TOTAL_FRAMES) begin
      if (frames_sent >= TOTAL_FRAMES - QUIET_FRAMES)
        quiet = 1'b1;
      if (!quiet && frames_sent >= next_cfg) begin
        case ($urandom_range(0, 3))
          0: begin
            chunk = $urandom_range(1, 16);
            limit = $urandom_range(1, 65535);
          end
          1: begin
            chunk = $urandom_range(1, 1023);
            limit = 65535;
          end
          default: begin
            chunk = $urandom_range(1, 1023);
            limit = $urandom_range(chunk, 65535);
          end
        endcase
        write_reg(frt_pkg::REG_CHUNK_SIZE, 16'(chunk));
        write_reg(frt_pkg::REG_MESSAGE_LIMIT, 16'(limit));
        next_cfg = frames_sent + CFG_SPAN;
      end
      if ($urandom_range(0, 7) == 0)
        send_frame(random_frame());
      else
        send_message();
    end
  endtask

  // Receiver side: random stall bursts, one long hold on request.
  initial begin : rx_side
    int n;
    int holds_done;
    holds_done = 0;
    out_stall = 1'b0;
    forever begin
      if (holds_done != hold_asks) begin
        holds_done = hold_asks;
        @(negedge clk);
        out_stall = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 16);
        @(negedge clk);
        out_stall = 1'b1;
        repeat (n - 1) @(negedge clk);
      end else begin
        n = $urandom_range(1, 16);
        @(negedge clk);
        out_stall = 1'b0;
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_verdicts
    frt_pkg::result_t got;
    frt_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      got.verdict      = frt_pkg::verdict_t'(verdict);
      got.write_offset = write_offset;
      got.kind         = deliver_kind;
      got.req          = deliver_request;
      got.sess         = deliver_session;
      got.length       = deliver_length;
      got.abandoned    = abandoned_pieces;
      results_seen++;
      if (awaited_verdicts.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("result %0d arrived with none outstanding, verdict %0d",
                   results_seen, verdict);
      end else begin
        want = awaited_verdicts.pop_front();
        if (got.verdict !== want.verdict || got.write_offset !== want.write_offset ||
            got.kind !== want.kind || got.req !== want.req || got.sess !== want.sess ||
            got.length !== want.length || got.abandoned !== want.abandoned) begin
          faults++;
          if (faults <= 10) begin
            $display("result %0d expected: verdict %0d off %0d kind %h req %h sess %h len %0d ab %0d",
                     results_seen, want.verdict, want.write_offset, want.kind, want.req,
                     want.sess, want.length, want.abandoned);
            $display("result %0d actual:   verdict %0d off %0d kind %h req %h sess %h len %0d ab %0d",
                     results_seen, got.verdict, got.write_offset, got.kind, got.req,
                     got.sess, got.length, got.abandoned);
          end
        end
      end
    end
  end

  // Ends the run if neither channel completes a transfer for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : run
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = frt_pkg::REG_CHUNK_SIZE;
    cfg_data      = '0;
    in_valid      = 1'b0;
    is_fragmented = 1'b0;
    message_seq   = '0;
    piece_index   = '0;
    piece_count   = '0;
    message_kind  = '0;
    request_tag   = '0;
    session_tag   = '0;
    piece_length  = '0;
    frames_sent   = 0;
    quiet         = 1'b0;
    hold_asks     = 0;
    chunk_bytes   = frt_pkg::CHUNK_SIZE_RESET;
    limit_bytes   = frt_pkg::MESSAGE_LIMIT_RESET;
    cur_seq       = '0;
    cur_kind      = '0;
    cur_req       = '0;
    cur_sess      = '0;
    clear_track();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_whole_frames();
    test_reassembly_cases();
    test_tight_registers();
    test_register_extremes();
    test_backpressure();
    test_random_traffic();

    drain_verdicts();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (faults == 0 && awaited_verdicts.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== fragment_reassembly_tracker_top.f =====
hdl/frt_pkg.sv
hdl/frt_tracker.sv
hdl/fragment_reassembly_tracker_top.sv
bench/tb_top.sv
